// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants and types for the button press classifier and counter.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int DIGITS      = 9;
  localparam int COUNT_W     = DIGITS * 4;
  localparam int DEBOUNCE_W  = 8;
  localparam int LONG_W      = 16;
  localparam int TIMER_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(20);
  localparam logic [LONG_W-1:0]     LONG_RST     = LONG_W'(2000);
  localparam logic [TIMER_W-1:0]    TIMER_MAX    = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_HOLD     = 4'b0100,
    PH_WAIT     = 4'b1000
  } phase_t;

  // Commands from the classifier to the BCD counter.
  typedef struct packed {
    logic inc;
    logic clr;
  } cnt_cmd_t;

endpackage

// ----- rtl/bpc_in_if.sv -----
// ----------------------------------------------------------------------------
// bpc_in_if
// Valid/ready channel that carries one button sample per transaction.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

// ----- rtl/bpc_out_if.sv -----
// ----------------------------------------------------------------------------
// bpc_out_if
// Valid/ready channel that carries the press event and the BCD count.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  import bpc_pkg::*;
  logic         valid;
  logic         ready;
  press_event_t press_event;
  count_t       count_bcd;

  modport source (output valid, output press_event, output count_bcd, input ready);
  modport sink   (input valid, input press_event, input count_bcd, output ready);
endinterface

// ----- rtl/bpc_bcd_counter.sv -----
// ----------------------------------------------------------------------------
// bpc_bcd_counter
// Packed BCD counter with increment (wrapping from all nines) and clear.
// ----------------------------------------------------------------------------
module bpc_bcd_counter (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::cnt_cmd_t cmd,
  output bpc_pkg::count_t   count_nxt
);
  import bpc_pkg::*;

  count_t            count_r;
  logic [DIGITS:0]   carry;

  // A digit steps when the increment reaches it through all lower nines.
  always_comb begin
    carry[0] = cmd.inc;
    count_nxt = count_r;
    for (int i = 0; i < DIGITS; i++) begin
      carry[i+1] = carry[i] && (count_r[i*4 +: 4] >= 4'd9);
      if (carry[i]) begin
        count_nxt[i*4 +: 4] = (count_r[i*4 +: 4] >= 4'd9) ? 4'd0 : count_r[i*4 +: 4] + 4'd1;
      end
    end
    if (cmd.clr) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/button_press_classifier_counter.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier_counter
// Debounced short/long press classifier driving a packed BCD press counter.
// ----------------------------------------------------------------------------
// The result of an accepted sample is written into the output register.
// Throughput: one sample per cycle while the output is not stalled; the phase, timer and counter update in one pass.
// A new sample is taken while the held result is being consumed in the same cycle.
// Reset (synchronous, active low): phase idle, timer and counter zero, registers
// at their defaults (debounce 20, long press 2000), output empty.
module button_press_classifier_counter (
  input  logic                                clk,
  input  logic                                rst_n,
  bpc_in_if.sink                              in_chan,
  bpc_out_if.source                           out_chan,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bpc_pkg::*;

  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [LONG_W-1:0]     long_r;
  phase_t                phase_r, phase_nxt;
  logic [TIMER_W-1:0]    timer_r, timer_nxt, timer_inc;
  press_event_t          event_nxt;
  logic                  out_valid_r;
  press_event_t          event_r;
  count_t                count_r;
  count_t                count_nxt;
  cnt_cmd_t              cmd;
  logic                  accept;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.press_event = event_r;
  assign out_chan.count_bcd   = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_LONG:     long_r     <= cfg_wdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  assign timer_inc = (timer_r == TIMER_MAX) ? timer_r : timer_r + TIMER_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    event_nxt = EV_NONE;
    cmd       = '0;
    case (phase_r)
      PH_IDLE: begin
        if (in_chan.button_pressed) begin
          timer_nxt = '0;
          phase_nxt = (debounce_r == '0) ? PH_HOLD : PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        // The button level is not looked at while debouncing.
        timer_nxt = timer_inc;
        if (timer_inc >= TIMER_W'(debounce_r)) begin
          timer_nxt = '0;
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (!in_chan.button_pressed) begin
          cmd.inc   = 1'b1;
          event_nxt = EV_SHORT;
          timer_nxt = '0;
          phase_nxt = PH_IDLE;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= TIMER_W'(long_r)) begin
            cmd.clr   = 1'b1;
            event_nxt = EV_LONG;
            timer_nxt = '0;
            phase_nxt = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (!in_chan.button_pressed) begin
          timer_nxt = '0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        timer_nxt = '0;
        phase_nxt = PH_IDLE;
      end
    endcase
    if (!accept) begin
      phase_nxt = phase_r;
      timer_nxt = timer_r;
      cmd       = '0;
    end
  end

  bpc_bcd_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .count_nxt (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_r <= event_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- test/bpc_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpc_result_checker
// Watches the sample and result channels of the press classifier. It keeps
// its own model of the debounce, hold timing and BCD counter, and compares
// every result transaction with the oldest prediction that is still waiting.
// ----------------------------------------------------------------------------
module bpc_result_checker
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bpc_in_if                     in_mon,
  bpc_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    awaited,
  output int                    short_presses,
  output int                    long_presses
);

  typedef enum logic [1:0] {
    SEEN_IDLE,
    SEEN_DEBOUNCE,
    SEEN_HOLD,
    SEEN_RELEASE_WAIT
  } sample_phase_t;

  typedef struct packed {
    press_event_t ev;
    count_t       count;
  } press_result_t;

  logic [DEBOUNCE_W-1:0] debounce_len;
  logic [LONG_W-1:0]     long_len;
  sample_phase_t         phase;
  logic [TIMER_W-1:0]    tick_count;
  logic [3:0]            digit [DIGITS];
  press_result_t         awaited_results [$];

  function automatic press_result_t classify_sample(input logic pressed);
    press_result_t res;
    logic          carry;
    res.ev = EV_NONE;
    res.count = '0;
    case (phase)
      SEEN_IDLE: begin
        if (pressed) begin
          tick_count = '0;
          phase = (debounce_len == '0) ? SEEN_HOLD : SEEN_DEBOUNCE;
        end
      end
      SEEN_DEBOUNCE: begin
        // The button level is not looked at while the debounce wait runs.
        if (tick_count != TIMER_MAX) tick_count = tick_count + 1'b1;
        if (tick_count >= TIMER_W'(debounce_len)) begin
          tick_count = '0;
          phase = SEEN_HOLD;
        end
      end
      SEEN_HOLD: begin
        if (!pressed) begin
          carry = 1'b1;
          for (int i = 0; i < DIGITS; i++) begin
            if (carry) begin
              if (digit[i] >= 4'd9) begin
                digit[i] = 4'd0;
              end else begin
                digit[i] = digit[i] + 4'd1;
                carry = 1'b0;
              end
            end
          end
          res.ev = EV_SHORT;
          tick_count = '0;
          phase = SEEN_IDLE;
        end else begin
          if (tick_count != TIMER_MAX) tick_count = tick_count + 1'b1;
          if (tick_count >= long_len) begin
            for (int i = 0; i < DIGITS; i++) digit[i] = 4'd0;
            res.ev = EV_LONG;
            tick_count = '0;
            phase = SEEN_RELEASE_WAIT;
          end
        end
      end
      default: begin
        if (!pressed) begin
          tick_count = '0;
          phase = SEEN_IDLE;
        end
      end
    endcase
    for (int i = 0; i < DIGITS; i++) res.count[4*i +: 4] = digit[i];
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    press_result_t want;
    if (!rst_n) begin
      debounce_len = DEBOUNCE_RST;
      long_len = LONG_RST;
      phase = SEEN_IDLE;
      tick_count = '0;
      for (int i = 0; i < DIGITS; i++) digit[i] = 4'd0;
      awaited_results.delete();
      mismatches = 0;
      short_presses = 0;
      long_presses = 0;
    end else begin
      // A result leaving at this edge belongs to a sample taken earlier, so
      // it is checked before a sample taken at this same edge is predicted.
      if (out_mon.valid && out_mon.ready) begin
        if (out_mon.press_event == EV_SHORT) short_presses++;
        if (out_mon.press_event == EV_LONG) long_presses++;
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result event %0d count %h with no sample waiting",
                                  out_mon.press_event, out_mon.count_bcd));
        end else begin
          want = awaited_results.pop_front();
          if (want.ev !== out_mon.press_event || want.count !== out_mon.count_bcd)
            flag_mismatch($sformatf("expected event %0d count %h, got event %0d count %h",
                                    want.ev, want.count, out_mon.press_event,
                                    out_mon.count_bcd));
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(classify_sample(in_mon.button_pressed));
      if (cfg_we) begin
        if (cfg_idx == CFG_DEBOUNCE) debounce_len = cfg_wdata[DEBOUNCE_W-1:0];
        else if (cfg_idx == CFG_LONG) long_len = cfg_wdata[LONG_W-1:0];
      end
    end
    awaited = awaited_results.size();
  end

endmodule

// ----- test/button_press_classifier_counter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_classifier_counter_tb
// Drives button samples and register writes into the press classifier with
// random gaps and output stalls. Directed presses cover the debounce and hold
// corner cases, including the longest debounce wait; random press sequences
// then run over several register settings.
// ----------------------------------------------------------------------------
module button_press_classifier_counter_tb;
  import bpc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit                    full_speed = 1'b0;
  int                    samples_sent = 0;
  int                    settings_used = 0;
  logic [DEBOUNCE_W-1:0] debounce_set = DEBOUNCE_RST;
  logic [LONG_W-1:0]     long_set = LONG_RST;

  int mismatches;
  int awaited;
  int short_presses;
  int long_presses;

  // Fill of the debounce ticks of a press.
  typedef enum int {FILL_HELD, FILL_RELEASED, FILL_RANDOM} bounce_fill_t;

  bpc_in_if  in_chan ();
  bpc_out_if out_chan ();

  button_press_classifier_counter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  bpc_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .short_presses (short_presses),
    .long_presses  (long_presses)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", awaited);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: bursts of ready with random stalls in between.
  initial begin
    int burst;
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (full_speed) begin
        @(negedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        burst = $urandom_range(1, 30);
        repeat (burst) begin
          @(negedge clk);
          out_chan.ready <= 1'b1;
        end
        stall = pick_gap();
        repeat (stall) begin
          @(negedge clk);
          out_chan.ready <= 1'b0;
        end
      end
    end
  end

  task automatic send_sample(input logic pressed);
    int gap;
    gap = full_speed ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.button_pressed <= pressed;
    do @(posedge clk); while (!in_chan.ready);
    samples_sent++;
  endtask

  task automatic send_level(input logic pressed, input int n);
    repeat (n) send_sample(pressed);
  endtask

  // Onset tick, the debounce ticks, then held ticks and optionally a release.
  task automatic send_press(input int held_ticks, input bit release_it,
                            input bounce_fill_t fill);
    send_sample(1'b1);
    repeat (debounce_set) begin
      case (fill)
        FILL_HELD:     send_sample(1'b1);
        FILL_RELEASED: send_sample(1'b0);
        default:       send_sample(1'($urandom_range(0, 1)));
      endcase
    end
    send_level(1'b1, held_ticks);
    if (release_it) send_sample(1'b0);
  endtask

  // Stops the sender and waits until every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEBOUNCE) debounce_set = value[DEBOUNCE_W-1:0];
    else long_set = value[LONG_W-1:0];
  endtask

  task automatic set_timing(input int unsigned debounce, input int unsigned long_hold);
    wait_drained();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_LONG, long_hold);
    settings_used++;
  endtask

  // Well-formed presses with random lengths, mixed with bursts of noise.
  task automatic random_presses(input int target);
    int start;
    int kind;
    int lim;
    int held;
    bounce_fill_t fill;
    start = samples_sent;
    while (samples_sent - start < target) begin
      kind = $urandom_range(0, 99);
      fill = bounce_fill_t'($urandom_range(0, 2));
      send_level(1'b0, $urandom_range(0, 3));
      if (kind < 12) begin
        repeat ($urandom_range(1, 10)) send_sample(1'($urandom_range(0, 1)));
      end else if (kind < 22 && long_set <= 64) begin
        held = (long_set == 0) ? 1 : int'(long_set);
        send_press(held + $urandom_range(0, 3), 1'b1, fill);
      end else begin
        lim = (long_set > 40) ? 40 : int'(long_set) - 1;
        held = (lim <= 0) ? 0 : $urandom_range(0, lim);
        send_press(held, 1'b1, fill);
      end
    end
    // Sometimes leave a press in progress across the next register write.
    if ($urandom_range(0, 2) == 0) send_level(1'b1, $urandom_range(1, 6));
  endtask

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.button_pressed <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_DEBOUNCE;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Default timing: a release during the debounce wait is still a short press.
    send_sample(1'b0);
    send_press(0, 1'b1, FILL_RELEASED);

    // No debounce, no hold time: long press, ignored hold, then a short press.
    set_timing(0, 0);
    send_press(2, 1'b1, FILL_HELD);
    send_press(0, 1'b1, FILL_HELD);

    set_timing(1, 1);
    random_presses(30);

    set_timing(0, 2);
    full_speed = 1'b1;
    random_presses(30);
    full_speed = 1'b0;

    // Longest debounce wait with a bouncing button, ending in a long press.
    set_timing(255, 1);
    send_press(1, 1'b1, FILL_RANDOM);

    // Quick presses with no long press possible carry the count past 99.
    set_timing(0, 65535);
    repeat (100) begin
      send_sample(1'b1);
      send_sample(1'b0);
      if ($urandom_range(0, 7) == 0) send_sample(1'b0);
    end

    repeat (4) begin
      set_timing($urandom_range(0, 5), $urandom_range(0, 12));
      full_speed = ($urandom_range(0, 3) == 0);
      random_presses(20);
    end
    full_speed = 1'b0;

    wait_drained();
    $display("Run covered %0d button samples over %0d register settings.",
             samples_sent, settings_used);
    $display("Presses classified: %0d short, %0d long.", short_presses, long_presses);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
